FILE: rtl/mi4_pkg.sv
package mi4_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 3 * WORD_BITS + 2;
    localparam int COF_BITS  = PROD_BITS + 3;
    localparam int DET_BITS  = COF_BITS + WORD_BITS + 2;
    localparam int NUM_BITS  = COF_BITS + 2 * FRAC_BITS;
    localparam int QCNT_BITS = $clog2(NUM_BITS + 1);

    typedef enum logic [6:0] {
        t_LOAD  = 7'b0000001,
        t_COF   = 7'b0000010,
        t_DET   = 7'b0000100,
        t_DIVI  = 7'b0001000,
        t_DIVS  = 7'b0010000,
        t_EMIT  = 7'b0100000,
        t_WAIT  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

    // row/column of the element of cofactor k, term t, factor f
    // minor(skip_r = k%4, skip_c = k/4); term t picks columns of the 3x3 minor
    function automatic logic [3:0] term_addr(input logic [3:0] k, input logic [2:0] t,
                                             input logic [1:0] f);
        logic [1:0] sr, sc;
        logic [1:0] rs [3];
        logic [1:0] cs [3];
        logic [1:0] perm [6][3];
        logic [1:0] ci;
        sr = k[1:0];
        sc = k[3:2];
        for (int i = 0; i < 3; i++) begin
            rs[i] = (2'(i) >= sr) ? 2'(i + 1) : 2'(i);
            cs[i] = (2'(i) >= sc) ? 2'(i + 1) : 2'(i);
        end
        perm[0] = '{2'd0, 2'd1, 2'd2};
        perm[1] = '{2'd0, 2'd2, 2'd1};
        perm[2] = '{2'd1, 2'd0, 2'd2};
        perm[3] = '{2'd1, 2'd2, 2'd0};
        perm[4] = '{2'd2, 2'd0, 2'd1};
        perm[5] = '{2'd2, 2'd1, 2'd0};
        ci = perm[(t > 3'd5) ? 3'd0 : t][f];
        return {rs[f], cs[ci]};
    endfunction

    // sign of a permutation term, combined with the cofactor sign (-1)^(r+c)
    function automatic logic term_neg(input logic [3:0] k, input logic [2:0] t);
        logic odd;
        odd = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
        return odd ^ k[0] ^ k[2];
    endfunction

endpackage

FILE: rtl/mi4_div.sv
// restoring divider, one quotient bit a cycle
module mi4_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mi4_pkg::t_div_ctl                  i_ctl,
    input  logic [mi4_pkg::NUM_BITS-1:0]       i_num,
    input  logic [mi4_pkg::DET_BITS-1:0]       i_den,
    output logic                               o_done,
    output logic [mi4_pkg::NUM_BITS-1:0]       o_quo
);
    logic [mi4_pkg::NUM_BITS-1:0]  r_q, n_q;
    logic [mi4_pkg::DET_BITS:0]    r_rem, n_rem, w_sh;
    logic [mi4_pkg::DET_BITS-1:0]  r_den;
    logic [mi4_pkg::QCNT_BITS-1:0] r_cnt, n_cnt;
    logic                          r_run, n_run, r_done, n_done;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_run = r_run; n_done = 1'b0;
        w_sh = {r_rem[mi4_pkg::DET_BITS-1:0], r_q[mi4_pkg::NUM_BITS-1]};
        if (i_ctl.start) begin
            n_q = i_num; n_rem = '0; n_run = 1'b1;
            n_cnt = mi4_pkg::QCNT_BITS'(mi4_pkg::NUM_BITS);
        end else if (r_run) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q = {r_q[mi4_pkg::NUM_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q = {r_q[mi4_pkg::NUM_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == mi4_pkg::QCNT_BITS'(1)) begin
                n_run = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_run <= n_run; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem;
        if (i_ctl.start) r_den <= i_den;
    end

    assign o_done = r_done && i_ctl.busy;
    assign o_quo  = r_q;
endmodule

FILE: rtl/matrix_inverse_4x4.sv
// 4x4 matrix inverse by cofactors, signed Q16.16.
// Input channel: i_element_valid/o_element_ready carry one element each;
// sixteen in row-major order form one matrix. Elements 1 to 15 are stored
// and give no result. After the sixteenth, one shared 34x32 multiplier
// forms the 96 triple products of the cofactors (each from the first two
// factors, then the low and high halves of that product times the third),
// then the determinant (three unsigned 32-bit slices and the signed top of
// each of four cofactors). A bit-serial divider then forms each result:
// load, 133 quotient bits, finish and output register. Results leave on
// o_result_valid/i_result_ready with index, last mark, singular and
// saturated flags.
// Each further result is computed only after the previous one is taken.
// The input is not ready during computation and emission.
// A zero determinant returns the stored matrix with singular set and skips
// the divider. Reset clears the load count and sequencer; stored elements
// are not cleared. A stalled receiver holds the result register and the
// sequencer.
module matrix_inverse_4x4 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_element_valid,
    output logic        o_element_ready,
    input  logic signed [31:0] i_element_value,
    output logic        o_result_valid,
    input  logic        i_result_ready,
    output logic signed [31:0] o_result_value,
    output logic [3:0]  o_result_index,
    output logic        o_last_element,
    output logic        o_singular,
    output logic        o_saturated
);
    localparam int WB = mi4_pkg::WORD_BITS;
    localparam int CB = mi4_pkg::COF_BITS;
    localparam int DB = mi4_pkg::DET_BITS;
    localparam int NB = mi4_pkg::NUM_BITS;

    logic signed [WB-1:0] r_mat [16];
    logic signed [CB-1:0] r_cof [16];
    mi4_pkg::t_state r_st, n_st;
    logic [3:0] r_cnt, r_k;
    logic [2:0] r_t;
    logic [1:0] r_ph;
    logic signed [2*WB+1:0] r_p1;
    logic signed [CB-1:0]   r_acc;
    logic signed [DB-1:0]   r_det;
    logic signed [DB-1:0]   w_dprod;
    logic [DB-1:0]          w_dmag;
    logic [CB-1:0]          w_cmag;
    logic                   r_neg;
    logic [NB-1:0]          w_quo;
    logic                   w_done;
    mi4_pkg::t_div_ctl      w_ctl;
    logic [WB-1:0]          w_lim, w_val;
    logic                   w_sat, w_high;
    logic [3:0]             w_ia, w_ib, w_ic;
    logic signed [CB-1:0]   w_dcof;
    logic signed [WB:0]     w_chunk;
    logic signed [WB+1:0]   w_ma;
    logic signed [WB-1:0]   w_mb;
    logic signed [2*WB+1:0] w_mprod;
    logic signed [CB-1:0]   w_term;
    logic signed [CB-1:0]   w_acc_n;

    assign o_element_ready = r_st == mi4_pkg::t_LOAD;

    always_comb begin
        w_ctl.start = r_st == mi4_pkg::t_DIVI;
        w_ctl.busy  = r_st == mi4_pkg::t_DIVS;
        w_dmag = r_det[DB-1] ? DB'(-r_det) : DB'(r_det);
        w_cmag = r_cof[r_k][CB-1] ? CB'(-r_cof[r_k]) : CB'(r_cof[r_k]);
        w_ia = mi4_pkg::term_addr(r_k, r_t, 2'd0);
        w_ib = mi4_pkg::term_addr(r_k, r_t, 2'd1);
        w_ic = mi4_pkg::term_addr(r_k, r_t, 2'd2);
        w_dcof = r_cof[{r_k[1:0], 2'd0}];
        // three unsigned 32-bit slices of the cofactor, then its signed top
        if (r_ph == 2'd3) begin
            w_chunk = (WB+1)'($signed(w_dcof[CB-1:3*WB]));
        end else begin
            w_chunk = {1'b0, w_dcof[{r_ph, 5'd0} +: WB]};
        end
        // operand select for the shared multiplier
        if (r_st == mi4_pkg::t_DET) begin
            w_ma = (WB+2)'(w_chunk);
            w_mb = r_mat[{2'd0, r_k[1:0]}];
        end else if (r_ph == 2'd0) begin
            w_ma = (WB+2)'(r_mat[w_ia]);
            w_mb = r_mat[w_ib];
        end else if (r_ph == 2'd1) begin
            w_ma = (WB+2)'({1'b0, r_p1[WB-1:0]});
            w_mb = r_mat[w_ic];
        end else begin
            w_ma = r_p1[2*WB+1:WB];
            w_mb = r_mat[w_ic];
        end
        w_mprod = w_ma * w_mb;
        w_term = (r_ph == 2'd1) ? CB'(w_mprod) : (CB'(w_mprod) <<< WB);
        w_acc_n = mi4_pkg::term_neg(r_k, r_t) ? r_acc - w_term : r_acc + w_term;
        w_dprod = DB'(w_mprod) <<< {r_ph, 5'd0};
        w_high = |w_quo[NB-1:WB];
        w_lim = r_neg ? WB'(1) << (WB - 1) : ~(WB'(1) << (WB - 1));
        w_sat = w_high || (w_quo[WB-1:0] > w_lim);
        w_val = w_sat ? w_lim : w_quo[WB-1:0];
    end

    mi4_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_num  ({w_cmag, (2 * mi4_pkg::FRAC_BITS)'(0)}),
        .i_den  (w_dmag),
        .o_done (w_done),
        .o_quo  (w_quo)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            mi4_pkg::t_LOAD: if (i_element_valid && r_cnt == 4'd15) n_st = mi4_pkg::t_COF;
            mi4_pkg::t_COF:  if (r_ph == 2'd2 && r_t == 3'd5 && r_k == 4'd15)
                n_st = mi4_pkg::t_DET;
            mi4_pkg::t_DET:  if (r_k == 4'd3 && r_ph == 2'd3) n_st = mi4_pkg::t_DIVI;
            mi4_pkg::t_DIVI: n_st = (r_det == '0) ? mi4_pkg::t_WAIT : mi4_pkg::t_DIVS;
            mi4_pkg::t_DIVS: if (w_done) n_st = mi4_pkg::t_WAIT;
            mi4_pkg::t_WAIT: n_st = mi4_pkg::t_EMIT;
            mi4_pkg::t_EMIT: if (i_result_ready)
                n_st = (r_k == 4'd15) ? mi4_pkg::t_LOAD : mi4_pkg::t_DIVI;
            default: n_st = mi4_pkg::t_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= mi4_pkg::t_LOAD; r_cnt <= '0; r_k <= '0; r_t <= '0; r_ph <= '0;
            o_result_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                mi4_pkg::t_LOAD: if (i_element_valid) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_k <= '0; r_t <= '0; r_ph <= 2'd0;
                end
                mi4_pkg::t_COF: begin
                    if (r_ph == 2'd2) begin
                        r_ph <= 2'd0;
                        if (r_t == 3'd5) begin
                            r_t <= '0;
                            r_k <= r_k + 1'b1;
                        end else begin
                            r_t <= r_t + 1'b1;
                        end
                    end else begin
                        r_ph <= r_ph + 2'd1;
                    end
                end
                mi4_pkg::t_DET: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd3) r_k <= (r_k == 4'd3) ? 4'd0 : r_k + 1'b1;
                end
                mi4_pkg::t_WAIT: o_result_valid <= 1'b1;
                mi4_pkg::t_EMIT: if (i_result_ready) begin
                    o_result_valid <= 1'b0;
                    r_k <= r_k + 1'b1;
                end
                default: ;
            endcase
        end
        if (r_st == mi4_pkg::t_LOAD && i_element_valid) r_mat[r_cnt] <= i_element_value;
        // stage one: first two factors; stages two and three add the low and
        // high halves of that product times the third
        if (r_st == mi4_pkg::t_COF) begin
            if (r_ph == 2'd0) begin
                r_p1 <= w_mprod;
            end else if (r_ph == 2'd2 && r_t == 3'd5) begin
                r_cof[r_k] <= w_acc_n;
                r_acc <= '0;
            end else begin
                r_acc <= w_acc_n;
            end
        end else if (r_st == mi4_pkg::t_LOAD) begin
            r_acc <= '0;
            r_det <= '0;
        end
        if (r_st == mi4_pkg::t_DET) r_det <= r_det + w_dprod;
        if (r_st == mi4_pkg::t_DIVI) r_neg <= r_cof[r_k][CB-1] ^ r_det[DB-1];
        if (r_st == mi4_pkg::t_WAIT) begin
            o_result_index <= r_k;
            o_last_element <= r_k == 4'd15;
            if (r_det == '0) begin
                o_result_value <= r_mat[r_k];
                o_singular <= 1'b1;
                o_saturated <= 1'b0;
            end else begin
                o_result_value <= r_neg ? -w_val : w_val;
                o_singular <= 1'b0;
                o_saturated <= w_sat;
            end
        end
    end
endmodule

FILE: rtl/mi4_check.sv
module mi4_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_element_valid,
    input logic        o_element_ready,
    input logic        o_result_valid,
    input logic        i_result_ready,
    input logic [31:0] o_result_value,
    input logic [3:0]  o_result_index,
    input logic        o_last_element,
    input logic        o_singular,
    input logic        o_saturated
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |=> o_result_valid && $stable(o_result_value))
        else $error("result dropped while stalled");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_last_element == (o_result_index == 4'd15)))
        else $error("last mark wrong");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_singular && o_saturated))
        else $error("singular and saturated together");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_result_valid && o_element_ready))
        else $error("input ready while emitting");
endmodule

bind matrix_inverse_4x4 mi4_check u_mi4_check (.*);
